// ===== hw/rtl/u8cell_pkg.sv =====
`default_nettype none

package u8cell_pkg;

   // width of the column and row counters
   localparam int COORD_BITS = 16;

   // width of the coordinates carried in a response
   localparam int CELL_COORD_BITS = 16;

   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;

   localparam logic [3:0] TAB_ADVANCE_RESET = 4'd4;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type   column;
      coord_type   row;
      logic [31:0] glyph;
      logic [1:0]  still_needed;
      logic [2:0]  collected;
   } placer_state_type;

   typedef struct packed {
      logic [2:0]                 length;
      logic [31:0]                bytes;
      logic [CELL_COORD_BITS-1:0] row;
      logic [CELL_COORD_BITS-1:0] column;
   } cell_type;

   // saturating add on the coordinate counters
   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic [COORD_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COORD_BITS] ? {COORD_BITS{1'b1}} : sum[COORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8cell_step.sv =====
`default_nettype none

module u8cell_step (
   input  wire logic [7:0]                  byte_in,
   input  wire logic                        start_of_text,
   input  wire logic [3:0]                  tab_advance,
   input  wire u8cell_pkg::placer_state_type state_cur,
   output u8cell_pkg::placer_state_type     state_next,
   output logic                             cell_valid,
   output u8cell_pkg::cell_type             cell_out
);

   u8cell_pkg::placer_state_type base;
   logic [31:0]                  glyph_merged;
   logic [31:0]                  cell_glyph;
   logic [2:0]                   cell_len;

   always_comb begin
      base = state_cur;
      if (start_of_text) begin
         base = '0;
      end

      glyph_merged = base.glyph;
      case (base.collected[1:0])
         2'd0: glyph_merged[31:24] = base.glyph[31:24] | byte_in;
         2'd1: glyph_merged[23:16] = base.glyph[23:16] | byte_in;
         2'd2: glyph_merged[15:8]  = base.glyph[15:8]  | byte_in;
         default: glyph_merged[7:0] = base.glyph[7:0] | byte_in;
      endcase

      state_next = base;
      cell_valid = 1'b0;
      cell_glyph = 32'd0;
      cell_len   = 3'd1;

      if (base.still_needed != 2'd0) begin
         if (byte_in[7:6] != 2'b10) begin
            // missing continuation: partial glyph and this byte dropped
            state_next.glyph        = 32'd0;
            state_next.still_needed = 2'd0;
            state_next.collected    = 3'd0;
         end else if (base.still_needed == 2'd1) begin
            cell_valid              = 1'b1;
            cell_glyph              = glyph_merged;
            cell_len                = base.collected + 3'd1;
            state_next.glyph        = 32'd0;
            state_next.still_needed = 2'd0;
            state_next.collected    = 3'd0;
            state_next.column       = u8cell_pkg::sat_add(base.column,
                                         u8cell_pkg::coord_type'(1));
         end else begin
            state_next.glyph        = glyph_merged;
            state_next.still_needed = base.still_needed - 2'd1;
            state_next.collected    = base.collected + 3'd1;
         end
      end else if (byte_in == u8cell_pkg::BYTE_NEWLINE) begin
         state_next.column = '0;
         state_next.row    = u8cell_pkg::sat_add(base.row, u8cell_pkg::coord_type'(1));
      end else if (byte_in == u8cell_pkg::BYTE_TAB) begin
         state_next.column = u8cell_pkg::sat_add(base.column,
                                u8cell_pkg::COORD_BITS'(tab_advance));
      end else if (byte_in == u8cell_pkg::BYTE_SPACE) begin
         state_next.column = u8cell_pkg::sat_add(base.column, u8cell_pkg::coord_type'(1));
      end else if (byte_in[7] == 1'b0) begin
         cell_valid        = 1'b1;
         cell_glyph        = {byte_in, 24'd0};
         cell_len          = 3'd1;
         state_next.column = u8cell_pkg::sat_add(base.column, u8cell_pkg::coord_type'(1));
      end else if (byte_in[7:5] == 3'b110) begin
         state_next.still_needed = 2'd1;
         state_next.glyph        = {byte_in, 24'd0};
         state_next.collected    = 3'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
         state_next.still_needed = 2'd2;
         state_next.glyph        = {byte_in, 24'd0};
         state_next.collected    = 3'd1;
      end else if (byte_in[7:3] == 5'b11110) begin
         state_next.still_needed = 2'd3;
         state_next.glyph        = {byte_in, 24'd0};
         state_next.collected    = 3'd1;
      end
      // lone continuation and invalid lead bytes fall through unchanged

      cell_out.column = u8cell_pkg::CELL_COORD_BITS'(base.column);
      cell_out.row    = u8cell_pkg::CELL_COORD_BITS'(base.row);
      cell_out.bytes  = cell_glyph;
      cell_out.length = cell_len;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/u8cell_rsp_reg.sv =====
`default_nettype none

module u8cell_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 cell_valid,
   input  wire u8cell_pkg::cell_type new_cell,
   output logic                      space_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output u8cell_pkg::cell_type      rsp_cell
);

   logic                 valid_ff;
   logic                 valid_in;
   u8cell_pkg::cell_type cell_ff;

   // free when empty or being drained this cycle
   assign space_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (load && cell_valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && cell_valid) begin
         cell_ff <= new_cell;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_cell   = cell_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_text_cell_placer_core.sv =====
`default_nettype none
// a request that completes a character gives its response in the cycle after acceptance
// throughput: one request per cycle while the response register has space, set by the state update loop
// requests that only move the cursor or collect bytes give no response
// reset: synchronous, active high; clears cursor, partial glyph and the response register,
// and sets tab_advance to 4
module utf8_text_cell_placer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tuser,   // [0] start_of_text
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [15:0] cell_column, [31:16] cell_row,
                                         // [63:32] glyph_bytes, [66:64] glyph_length,
                                         // [71:67] zero
   // configuration channel: tab_advance
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data
);

   u8cell_pkg::placer_state_type state_ff;
   u8cell_pkg::placer_state_type state_in;
   u8cell_pkg::placer_state_type state_step;
   logic [3:0]                   tab_advance_ff;
   logic                         accept;
   logic                         cell_valid;
   u8cell_pkg::cell_type         step_cell;
   u8cell_pkg::cell_type         rsp_cell;
   logic                         space_free;

   // the user must make register writes only while idle; the block does not enforce this and is always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_advance_ff <= u8cell_pkg::TAB_ADVANCE_RESET;
      end else if (csr_valid) begin
         tab_advance_ff <= csr_data;
      end
   end

   // a new request is taken whenever the response register can hold its result
   assign req_tready = space_free;
   assign accept     = req_tvalid && req_tready;

   // decode of one byte against the cursor and partial glyph state
   u8cell_step u_step (
      .byte_in       (req_tdata),
      .start_of_text (req_tuser),
      .tab_advance   (tab_advance_ff),
      .state_cur     (state_ff),
      .state_next    (state_step),
      .cell_valid    (cell_valid),
      .cell_out      (step_cell)
   );

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = state_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // response register, decouples the request side from a stalled consumer
   u8cell_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .cell_valid (cell_valid),
      .new_cell   (step_cell),
      .space_free (space_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cell   (rsp_cell)
   );

   assign rsp_tdata = {5'd0, rsp_cell.length, rsp_cell.bytes, rsp_cell.row, rsp_cell.column};

endmodule

`default_nettype wire

// ===== hw/rtl/u8cell_checker.sv =====
`default_nettype none

module u8cell_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // request side only stalls behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request stalled without a stalled response");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // length is 1 to 4 and the bytes beyond it are zero
   a_glyph_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ((rsp_tdata[66:64] == 3'd1 && rsp_tdata[55:32] == 24'd0) ||
          (rsp_tdata[66:64] == 3'd2 && rsp_tdata[47:32] == 16'd0) ||
          (rsp_tdata[66:64] == 3'd3 && rsp_tdata[39:32] == 8'd0) ||
          (rsp_tdata[66:64] == 3'd4)))
      else $error("bad glyph length or stray bytes");

   // a response only follows an accepted request or a held response
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_tvalid)) |-> $past(req_tvalid && req_tready))
      else $error("response without a request");

endmodule

bind utf8_text_cell_placer_core u8cell_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
